[sv/lcsr_pkg.sv]
`timescale 1ns / 1ps

package lcsr_pkg;

    localparam int DATA_BITS = 24;
    localparam int TICK_W    = 24;
    localparam int COUNT_W   = 8;
    localparam int HALF_W    = 16;
    localparam int GAIN_W    = 2;
    localparam int SUM_W     = 32;
    localparam int BIT_W     = 5;
    localparam int STEP_W    = 5;
    localparam int INDEX_W   = 3;

    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_TARE    = 2'd2;

    localparam logic [INDEX_W-1:0] REG_GAIN    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COUNT   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_HALF    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_GAP     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_TIMEOUT = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_RST    = 2'd0;
    localparam logic [GAIN_W-1:0]  GAIN_NONE   = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_RST   = 8'd1;
    localparam logic [HALF_W-1:0]  HALF_RST    = 16'd1;
    localparam logic [TICK_W-1:0]  GAP_RST     = 24'd0;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST = 24'd10000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_PAUSE,
        PH_GAP
    } phase_t;

    typedef enum logic [1:0] {
        C_RUN,
        C_DIV_LOAD,
        C_DIV,
        C_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       data_pin;
    } tick_t;

    typedef struct packed {
        logic                 clock_pin;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] average;
        logic                 was_tare;
        logic [DATA_BITS-1:0] tare_offset;
    } result_t;

    typedef struct packed {
        logic tick_clear;
        logic tick_inc;
        logic bit_clear;
        logic bit_inc;
        logic shift_clear;
        logic shift_in;
        logic op_start;
        logic op_tare;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic finish;
        logic load_out;
        logic out_clock;
        logic out_busy;
    } cmd_t;

    typedef struct packed {
        logic timeout_hit;
        logic half_hit;
        logic gap_hit;
        logic gap_zero;
        logic bit_lt_data;
        logic next_lt_data;
        logic next_eq_data;
        logic next_lt_total;
        logic bit_lt_total;
        logic fin_count_hit;
        logic gap_count_hit;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

[sv/lcsr_tick_if.sv]
`timescale 1ns / 1ps

interface lcsr_tick_if import lcsr_pkg::*; ();
    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/lcsr_result_if.sv]
`timescale 1ns / 1ps

interface lcsr_result_if import lcsr_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/load_cell_adc_serial_reader.sv]
// A tick that does not complete an average has its result registered in the cycle after its transfer.
// Throughput: such ticks are taken one per cycle while the result side keeps up.
// A tick that completes an average goes through the divider load, divide and finish states,
// where the shift-subtract divider produces one quotient bit per cycle over the 32-bit sum.
// Reset: rst_n low clears all control state at once and restores the register defaults.
`timescale 1ns / 1ps

module load_cell_adc_serial_reader import lcsr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               write_en,
    input  logic [INDEX_W-1:0] write_index,
    input  logic [TICK_W-1:0]  write_data,
    lcsr_tick_if.sink          tick,
    lcsr_result_if.source      result
);

    cmd_t    cmd;
    status_t status;

    lcsr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .tick_data  (tick.data),
        .status     (status),
        .cmd        (cmd)
    );

    lcsr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .data_pin    (tick.data.data_pin),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

endmodule

[sv/lcsr_ctrl.sv]
`timescale 1ns / 1ps

module lcsr_ctrl import lcsr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_valid,
    output logic    tick_ready,
    input  tick_t   tick_data,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        op_done;
    logic        finish_rd;
    logic        gap_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_RUN;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        tick_ready = 1'b0;
        op_done    = 1'b0;
        finish_rd  = 1'b0;
        gap_end    = 1'b0;

        case (state_reg)
            C_RUN:
            begin
                tick_ready = status.out_free;
                if (tick_valid && status.out_free)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (tick_data.kind == KIND_MEASURE || tick_data.kind == KIND_TARE)
                            begin
                                cmd.op_start   = 1'b1;
                                cmd.op_tare    = (tick_data.kind == KIND_TARE);
                                cmd.tick_clear = 1'b1;
                                phase_next     = PH_WAIT;
                            end
                        end
                        PH_WAIT:
                        begin
                            if (!tick_data.data_pin || status.timeout_hit)
                            begin
                                cmd.bit_clear   = 1'b1;
                                cmd.shift_clear = 1'b1;
                                cmd.tick_clear  = 1'b1;
                                phase_next      = PH_HIGH;
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        PH_HIGH:
                        begin
                            cmd.out_clock = 1'b1;
                            if (status.half_hit)
                            begin
                                cmd.shift_in   = status.bit_lt_data;
                                cmd.tick_clear = 1'b1;
                                phase_next     = PH_LOW;
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        PH_LOW:
                        begin
                            if (status.half_hit)
                            begin
                                cmd.bit_inc    = 1'b1;
                                cmd.tick_clear = 1'b1;
                                if (status.next_lt_data)
                                begin
                                    phase_next = PH_HIGH;
                                end
                                else if (status.next_eq_data || status.next_lt_total)
                                begin
                                    phase_next = PH_PAUSE;
                                end
                                else
                                begin
                                    finish_rd = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        PH_PAUSE:
                        begin
                            if (status.half_hit)
                            begin
                                cmd.tick_clear = 1'b1;
                                if (status.bit_lt_total)
                                begin
                                    phase_next = PH_HIGH;
                                end
                                else
                                begin
                                    finish_rd = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        PH_GAP:
                        begin
                            if (status.gap_hit)
                            begin
                                gap_end = 1'b1;
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase

                    if (finish_rd)
                    begin
                        cmd.accumulate = 1'b1;
                        cmd.tick_clear = 1'b1;
                        if (!status.gap_zero)
                        begin
                            phase_next = PH_GAP;
                        end
                        else if (status.fin_count_hit)
                        begin
                            op_done    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end

                    if (gap_end)
                    begin
                        if (status.gap_count_hit)
                        begin
                            op_done    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cmd.tick_clear = 1'b1;
                            phase_next     = PH_WAIT;
                        end
                    end

                    if (op_done)
                    begin
                        state_next = C_DIV_LOAD;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_busy = (phase_next != PH_IDLE);
                    end
                end
            end
            C_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = C_DIV;
            end
            C_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = C_FINISH;
                end
            end
            C_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = C_RUN;
            end
            default:
            begin
                state_next = C_RUN;
            end
        endcase
    end

endmodule

[sv/lcsr_dpath.sv]
`timescale 1ns / 1ps

module lcsr_dpath import lcsr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_en,
    input  logic [INDEX_W-1:0]   write_index,
    input  logic [TICK_W-1:0]    write_data,
    input  logic                 data_pin,
    input  cmd_t                 cmd,
    output status_t              status,
    lcsr_result_if.source        result
);

    logic [GAIN_W-1:0]    gain_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [HALF_W-1:0]    half_reg;
    logic [TICK_W-1:0]    gap_reg;
    logic [TICK_W-1:0]    timeout_reg;

    logic [TICK_W-1:0]    tick_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [DATA_BITS-1:0] shift_reg;
    logic [COUNT_W-1:0]   readings_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 tare_reg;
    logic [DATA_BITS-1:0] offset_reg;

    logic [SUM_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   divisor_reg;
    logic [STEP_W-1:0]    step_reg;

    logic                 out_valid_reg;
    result_t              out_reg;

    logic [TICK_W-1:0]    tick_next;
    logic [BIT_W-1:0]     bit_next;
    logic [BIT_W-1:0]     total_pulses;
    logic [GAIN_W-1:0]    extra_pulses;
    logic [COUNT_W-1:0]   count_eff;
    logic [COUNT_W-1:0]   readings_next;
    logic [DATA_BITS-1:0] magnitude;
    logic [COUNT_W:0]     trial;
    logic                 trial_ge;
    logic [DATA_BITS-1:0] quotient;

    assign tick_next     = tick_reg + 1'b1;
    assign bit_next      = bit_reg + 1'b1;
    assign extra_pulses  = (gain_reg == GAIN_NONE) ? '0 : gain_reg + 1'b1;
    assign total_pulses  = BIT_W'(DATA_BITS) + BIT_W'(extra_pulses);
    assign count_eff     = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign readings_next = readings_reg + 1'b1;
    assign magnitude     = shift_reg[DATA_BITS-1] ? (~shift_reg + 1'b1) : shift_reg;
    assign trial         = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge      = (trial >= {1'b0, divisor_reg});
    assign quotient      = quo_reg[DATA_BITS-1:0];

    always_comb
    begin
        status.timeout_hit   = (tick_reg >= timeout_reg);
        status.half_hit      = (tick_next >= TICK_W'(half_reg));
        status.gap_hit       = (tick_next >= gap_reg);
        status.gap_zero      = (gap_reg == '0);
        status.bit_lt_data   = (bit_reg < BIT_W'(DATA_BITS));
        status.next_lt_data  = (bit_next < BIT_W'(DATA_BITS));
        status.next_eq_data  = (bit_next == BIT_W'(DATA_BITS));
        status.next_lt_total = (bit_next < total_pulses);
        status.bit_lt_total  = (bit_reg < total_pulses);
        status.fin_count_hit = (readings_next >= count_eff);
        status.gap_count_hit = (readings_reg >= count_eff);
        status.div_last      = (step_reg == '1);
        status.out_free      = !out_valid_reg || result.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RST;
            count_reg   <= COUNT_RST;
            half_reg    <= HALF_RST;
            gap_reg     <= GAP_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (write_en)
        begin
            case (write_index)
                REG_GAIN:    gain_reg    <= write_data[GAIN_W-1:0];
                REG_COUNT:   count_reg   <= write_data[COUNT_W-1:0];
                REG_HALF:    half_reg    <= write_data[HALF_W-1:0];
                REG_GAP:     gap_reg     <= write_data;
                REG_TIMEOUT: timeout_reg <= write_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            readings_reg <= '0;
            sum_reg      <= '0;
            tare_reg     <= 1'b0;
            offset_reg   <= '0;
            step_reg     <= '0;
        end
        else
        begin
            if (cmd.tick_clear)
            begin
                tick_reg <= '0;
            end
            else if (cmd.tick_inc)
            begin
                tick_reg <= tick_next;
            end

            if (cmd.bit_clear)
            begin
                bit_reg <= '0;
            end
            else if (cmd.bit_inc)
            begin
                bit_reg <= bit_next;
            end

            if (cmd.shift_clear)
            begin
                shift_reg <= '0;
            end
            else if (cmd.shift_in)
            begin
                shift_reg <= {shift_reg[DATA_BITS-2:0], data_pin};
            end

            if (cmd.op_start)
            begin
                readings_reg <= '0;
                sum_reg      <= '0;
                tare_reg     <= cmd.op_tare;
            end
            else if (cmd.accumulate)
            begin
                readings_reg <= readings_next;
                sum_reg      <= sum_reg + SUM_W'(magnitude);
            end

            if (cmd.div_load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (cmd.finish && tare_reg)
            begin
                offset_reg <= quotient;
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg     <= sum_reg;
            rem_reg     <= '0;
            divisor_reg <= (readings_reg == '0) ? COUNT_W'(1) : readings_reg;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? COUNT_W'(trial - {1'b0, divisor_reg}) : trial[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out || cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.clock_pin   <= 1'b0;
            out_reg.busy_res    <= 1'b0;
            out_reg.done_res    <= 1'b1;
            out_reg.average     <= quotient;
            out_reg.was_tare    <= tare_reg;
            out_reg.tare_offset <= tare_reg ? quotient : offset_reg;
        end
        else if (cmd.load_out)
        begin
            out_reg.clock_pin   <= cmd.out_clock;
            out_reg.busy_res    <= cmd.out_busy;
            out_reg.done_res    <= 1'b0;
            out_reg.average     <= '0;
            out_reg.was_tare    <= 1'b0;
            out_reg.tare_offset <= offset_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

[sv/lcsr_checker.sv]
`timescale 1ns / 1ps

module lcsr_checker import lcsr_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    tick_valid,
    input logic    tick_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    logic                 tick_xfer;
    logic                 res_xfer;
    logic [1:0]           pending_reg;
    logic [DATA_BITS-1:0] offset_seen_reg;

    assign tick_xfer = tick_valid && tick_ready;
    assign res_xfer  = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            offset_seen_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(tick_xfer) - 2'(res_xfer);
            if (res_xfer)
            begin
                offset_seen_reg <= result_data.tare_offset;
            end
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // Only one tick is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |-> (pending_reg == 2'd0 || res_xfer))
        else $error("tick taken while an earlier result is outstanding");

    // Every presented result belongs to exactly one transferred tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg == 2'd1)
        else $error("result without a matching tick");

    // The offset moves only when a tare completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && !(result_data.done_res && result_data.was_tare)
        |-> result_data.tare_offset == offset_seen_reg)
        else $error("tare offset changed outside a tare");

endmodule

bind load_cell_adc_serial_reader lcsr_checker u_lcsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
